// ===== hw/rtl/clsu_pkg.sv =====
package clsu_pkg;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_HWR   = 2'd1,
    KIND_HRD   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_BAD, OP_NOP, OP_SEI, OP_LD, OP_ST, OP_AND, OP_ORA, OP_EOR, OP_BIT,
    OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS, OP_HWR
  } op_t;

  typedef enum logic [3:0] {
    M_NONE, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY, M_HRD
  } mode_t;

  typedef enum logic [1:0] {
    R_A = 2'd0,
    R_X = 2'd1,
    R_Y = 2'd2
  } reg_sel_t;

  // one classified item in the queue
  typedef struct packed {
    op_t      op;
    mode_t    mode;
    reg_sel_t rsel;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] data;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PTR0, ST_PTR1, ST_DATA, ST_WAIT, ST_DONE
  } exec_state_t;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;
  localparam logic [7:0] FLAG_N      = 8'b1000_0000;
  localparam logic [7:0] FLAG_V      = 8'b0100_0000;
  localparam logic [7:0] FLAG_I      = 8'h04;
  localparam logic [7:0] FLAG_Z      = 8'h02;

  // opcode decoder
  function automatic uop_t classify(logic [1:0] kind, logic [7:0] opc,
                                    logic [7:0] lo, logic [7:0] hi, logic [7:0] hd);
    uop_t u;
    u.op = OP_BAD; u.mode = M_NONE; u.rsel = R_A;
    u.lo = lo; u.hi = hi; u.data = hd;
    unique case (kind)
      KIND_HWR: u.op = OP_HWR;
      KIND_HRD: begin u.op = OP_NOP; u.mode = M_HRD; end
      KIND_BAD: u.op = OP_BAD;
      default: begin
        unique case (opc)
          8'h00, 8'hF8: u.op = OP_NOP;
          8'h78: u.op = OP_SEI;
          8'hA2: begin u.op = OP_LD; u.mode = M_IMM; u.rsel = R_X; end
          8'hA6: begin u.op = OP_LD; u.mode = M_ZP;  u.rsel = R_X; end
          8'hB6: begin u.op = OP_LD; u.mode = M_ZPY; u.rsel = R_X; end
          8'hAE: begin u.op = OP_LD; u.mode = M_ABS; u.rsel = R_X; end
          8'hBE: begin u.op = OP_LD; u.mode = M_ABY; u.rsel = R_X; end
          8'hA0: begin u.op = OP_LD; u.mode = M_IMM; u.rsel = R_Y; end
          8'hA4: begin u.op = OP_LD; u.mode = M_ZP;  u.rsel = R_Y; end
          8'hB4: begin u.op = OP_LD; u.mode = M_ZPX; u.rsel = R_Y; end
          8'hAC: begin u.op = OP_LD; u.mode = M_ABS; u.rsel = R_Y; end
          8'hBC: begin u.op = OP_LD; u.mode = M_ABX; u.rsel = R_Y; end
          8'hA9: begin u.op = OP_LD; u.mode = M_IMM; end
          8'hA5: begin u.op = OP_LD; u.mode = M_ZP;  end
          8'hB5: begin u.op = OP_LD; u.mode = M_ZPX; end
          8'hAD: begin u.op = OP_LD; u.mode = M_ABS; end
          8'hBD: begin u.op = OP_LD; u.mode = M_ABX; end
          8'hB9: begin u.op = OP_LD; u.mode = M_ABY; end
          8'hA1: begin u.op = OP_LD; u.mode = M_INX; end
          8'hB1: begin u.op = OP_LD; u.mode = M_INY; end
          8'h84: begin u.op = OP_ST; u.mode = M_ZP;  u.rsel = R_Y; end
          8'h94: begin u.op = OP_ST; u.mode = M_ZPX; u.rsel = R_Y; end
          8'h8C: begin u.op = OP_ST; u.mode = M_ABS; u.rsel = R_Y; end
          8'h86: begin u.op = OP_ST; u.mode = M_ZP;  u.rsel = R_X; end
          8'h96: begin u.op = OP_ST; u.mode = M_ZPY; u.rsel = R_X; end
          8'h8E: begin u.op = OP_ST; u.mode = M_ABS; u.rsel = R_X; end
          8'h85: begin u.op = OP_ST; u.mode = M_ZP;  end
          8'h95: begin u.op = OP_ST; u.mode = M_ZPX; end
          8'h8D: begin u.op = OP_ST; u.mode = M_ABS; end
          8'h9D: begin u.op = OP_ST; u.mode = M_ABX; end
          8'h99: begin u.op = OP_ST; u.mode = M_ABY; end
          8'h81: begin u.op = OP_ST; u.mode = M_INX; end
          8'h91: begin u.op = OP_ST; u.mode = M_INY; end
          8'hAA: u.op = OP_TAX;
          8'hA8: u.op = OP_TAY;
          8'h8A: u.op = OP_TXA;
          8'h98: u.op = OP_TYA;
          8'hBA: u.op = OP_TSX;
          8'h9A: u.op = OP_TXS;
          8'h24: begin u.op = OP_BIT; u.mode = M_ZP;  end
          8'h2C: begin u.op = OP_BIT; u.mode = M_ABS; end
          default: begin
            // logic group shares one column layout
            case (opc[7:5])
              3'b001:  u.op = OP_AND;
              3'b000:  u.op = OP_ORA;
              3'b010:  u.op = OP_EOR;
              default: u.op = OP_BAD;
            endcase
            unique case (opc[4:0])
              5'h09: u.mode = M_IMM;
              5'h05: u.mode = M_ZP;
              5'h15: u.mode = M_ZPX;
              5'h0D: u.mode = M_ABS;
              5'h1D: u.mode = M_ABX;
              5'h19: u.mode = M_ABY;
              5'h01: u.mode = M_INX;
              5'h11: u.mode = M_INY;
              default: u.op = OP_BAD;
            endcase
            if (u.op == OP_BAD) u.mode = M_NONE;
          end
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/cpu_load_store_logic_unit.sv =====
// Executes a subset of 6502 load, store, transfer and logic instructions plus
// host memory writes and reads, one result item per input item. A two-entry
// queue separates decode from the execute sequencer, so new items are taken
// while earlier ones run or their results wait. The execute side handles one
// item at a time over the single-ported data memory. Register, immediate and
// direct store items go from ST_PTR0 to ST_DONE, direct reads add ST_WAIT, and
// (zp,X) and (zp),Y read the pointer in ST_PTR0 and ST_PTR1, then ST_DATA and,
// for reads, ST_WAIT. Memory holds 2^MEM_ADDR_BITS bytes, addresses keep their
// low bits, and it has no reset: bytes must be written before they are read.
module cpu_load_store_logic_unit #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_opcode,
  input  logic [7:0] in_operand_lo,
  input  logic [7:0] in_operand_hi,
  input  logic [7:0] in_host_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [7:0] out_acc,
  output logic [7:0] out_xreg,
  output logic [7:0] out_yreg,
  output logic [7:0] out_stack_ptr,
  output logic [7:0] out_flags,
  output logic [7:0] out_read_byte
);

  logic           q_valid, q_ready;
  clsu_pkg::uop_t q_uop;

  clsu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_opcode, .in_operand_lo,
    .in_operand_hi, .in_host_data, .q_valid, .q_ready, .q_uop
  );

  clsu_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_uop, .out_valid, .out_ready,
    .out_status, .out_acc, .out_xreg, .out_yreg, .out_stack_ptr, .out_flags,
    .out_read_byte
  );

`ifndef SYNTHESIS
  // bit 5 of the status byte always reads one
  a_flag5: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flags[5]) else $error("flag bit 5 cleared");

  // a rejected item leaves the read byte at zero
  a_bad_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_read_byte == 8'h00))
    else $error("rejected item with read data");

  // decimal flag never set
  a_dflag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_flags[3]) else $error("decimal flag set");
`endif

endmodule

// ===== hw/rtl/clsu_front.sv =====
module clsu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_opcode,
  input  logic [7:0]          in_operand_lo,
  input  logic [7:0]          in_operand_hi,
  input  logic [7:0]          in_host_data,
  output logic                q_valid,
  input  logic                q_ready,
  output clsu_pkg::uop_t      q_uop
);

  clsu_pkg::uop_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  // two-entry queue between decode and execute
  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_uop    = slot_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= clsu_pkg::classify(in_kind, in_opcode, in_operand_lo,
                                         in_operand_hi, in_host_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/clsu_back.sv =====
module clsu_back #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  clsu_pkg::uop_t q_uop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_status,
  output logic [7:0]     out_acc,
  output logic [7:0]     out_xreg,
  output logic [7:0]     out_yreg,
  output logic [7:0]     out_stack_ptr,
  output logic [7:0]     out_flags,
  output logic [7:0]     out_read_byte
);

  logic [7:0] mem [2**MEM_ADDR_BITS];

  clsu_pkg::exec_state_t state_r, state_nxt;
  clsu_pkg::uop_t        u_r;
  logic [7:0]  a_r, x_r, y_r, sp_r, p_r;
  logic [7:0]  a_nxt, x_nxt, y_nxt, sp_nxt, p_nxt;
  logic [7:0]  ptr_lo_r, ptr_lo_nxt;
  logic [15:0] addr;
  logic [7:0]  rdata_r;
  logic        mem_re, mem_we;
  logic [7:0]  wdata;
  logic        take;
  logic [7:0]  m, res, stv;
  logic        status_nxt;
  logic [7:0]  rb_nxt;
  logic        fin;
  logic        ovalid_r;
  logic        ostatus_r;
  logic [7:0]  oa_r, ox_r, oy_r, osp_r, op_r, orb_r;
  logic        out_free;

  assign out_free = !ovalid_r || out_ready;

  // memory port: one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr[MEM_ADDR_BITS-1:0]] <= wdata;
    if (mem_re) rdata_r <= mem[addr[MEM_ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clsu_pkg::ST_IDLE;
      a_r  <= 8'h00;
      x_r  <= 8'h00;
      y_r  <= 8'h00;
      sp_r <= clsu_pkg::SP_RESET;
      p_r  <= clsu_pkg::FLAGS_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
      if (fin) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) u_r <= q_uop;
    ptr_lo_r <= ptr_lo_nxt;
    if (fin) begin
      ostatus_r <= status_nxt;
      oa_r <= a_nxt; ox_r <= x_nxt; oy_r <= y_nxt; osp_r <= sp_nxt; op_r <= p_nxt;
      orb_r <= rb_nxt;
    end
  end

  // source register for stores
  always_comb begin
    case (u_r.rsel)
      clsu_pkg::R_X: stv = x_r;
      clsu_pkg::R_Y: stv = y_r;
      default:       stv = a_r;
    endcase
  end

  // sequencer: address, memory access and write back
  always_comb begin
    state_nxt  = state_r;
    take       = 1'b0;
    q_ready    = 1'b0;
    addr       = 16'h0000;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    wdata      = stv;
    ptr_lo_nxt = ptr_lo_r;
    fin        = 1'b0;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    status_nxt = 1'b0;
    rb_nxt     = 8'h00;
    m          = u_r.lo;
    res        = 8'h00;
    unique case (state_r)
      clsu_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          take = 1'b1;
          state_nxt = clsu_pkg::ST_PTR0;
        end
      end
      clsu_pkg::ST_PTR0: begin
        // first access: pointer low, data, or host
        case (u_r.mode)
          clsu_pkg::M_INX: begin
            addr = {8'h00, u_r.lo + x_r}; mem_re = 1'b1; state_nxt = clsu_pkg::ST_PTR1;
          end
          clsu_pkg::M_INY: begin
            addr = {8'h00, u_r.lo}; mem_re = 1'b1; state_nxt = clsu_pkg::ST_PTR1;
          end
          clsu_pkg::M_NONE, clsu_pkg::M_IMM: begin
            if (u_r.op == clsu_pkg::OP_HWR) begin
              addr = {u_r.hi, u_r.lo}; mem_we = 1'b1; wdata = u_r.data;
            end
            state_nxt = clsu_pkg::ST_DONE;
          end
          default: begin
            case (u_r.mode)
              clsu_pkg::M_ZP:  addr = {8'h00, u_r.lo};
              clsu_pkg::M_ZPX: addr = {8'h00, u_r.lo + x_r};
              clsu_pkg::M_ZPY: addr = {8'h00, u_r.lo + y_r};
              clsu_pkg::M_ABX: addr = {u_r.hi, u_r.lo} + {8'h00, x_r};
              clsu_pkg::M_ABY: addr = {u_r.hi, u_r.lo} + {8'h00, y_r};
              default:         addr = {u_r.hi, u_r.lo};
            endcase
            if (u_r.op == clsu_pkg::OP_ST) begin
              mem_we = 1'b1; state_nxt = clsu_pkg::ST_DONE;
            end else begin
              mem_re = 1'b1; state_nxt = clsu_pkg::ST_WAIT;
            end
          end
        endcase
      end
      clsu_pkg::ST_PTR1: begin
        // pointer high from page zero
        ptr_lo_nxt = rdata_r;
        if (u_r.mode == clsu_pkg::M_INX) addr = {8'h00, u_r.lo + x_r + 8'h01};
        else                              addr = {8'h00, u_r.lo + 8'h01};
        mem_re = 1'b1;
        state_nxt = clsu_pkg::ST_DATA;
      end
      clsu_pkg::ST_DATA: begin
        if (u_r.mode == clsu_pkg::M_INY) addr = {rdata_r, ptr_lo_r} + {8'h00, y_r};
        else                              addr = {rdata_r, ptr_lo_r};
        if (u_r.op == clsu_pkg::OP_ST) begin
          mem_we = 1'b1; state_nxt = clsu_pkg::ST_DONE;
        end else begin
          mem_re = 1'b1; state_nxt = clsu_pkg::ST_WAIT;
        end
      end
      clsu_pkg::ST_WAIT: state_nxt = clsu_pkg::ST_DONE;
      clsu_pkg::ST_DONE: begin
        if (out_free) begin
          fin = 1'b1;
          state_nxt = clsu_pkg::ST_IDLE;
          if (u_r.mode != clsu_pkg::M_IMM) m = rdata_r;
          case (u_r.op)
            clsu_pkg::OP_BAD: status_nxt = 1'b1;
            clsu_pkg::OP_SEI: p_nxt = p_r | clsu_pkg::FLAG_I;
            clsu_pkg::OP_LD: begin
              res = m;
              case (u_r.rsel)
                clsu_pkg::R_X: x_nxt = m;
                clsu_pkg::R_Y: y_nxt = m;
                default:       a_nxt = m;
              endcase
            end
            clsu_pkg::OP_AND: begin res = a_r & m; a_nxt = res; end
            clsu_pkg::OP_ORA: begin res = a_r | m; a_nxt = res; end
            clsu_pkg::OP_EOR: begin res = a_r ^ m; a_nxt = res; end
            clsu_pkg::OP_TAX: begin res = a_r;  x_nxt = res; end
            clsu_pkg::OP_TAY: begin res = a_r;  y_nxt = res; end
            clsu_pkg::OP_TXA: begin res = x_r;  a_nxt = res; end
            clsu_pkg::OP_TYA: begin res = y_r;  a_nxt = res; end
            clsu_pkg::OP_TSX: begin res = sp_r; x_nxt = res; end
            clsu_pkg::OP_TXS: sp_nxt = x_r;
            clsu_pkg::OP_BIT: begin
              p_nxt = (p_r & ~(clsu_pkg::FLAG_N | clsu_pkg::FLAG_V | clsu_pkg::FLAG_Z))
                    | (m & (clsu_pkg::FLAG_N | clsu_pkg::FLAG_V))
                    | (((a_r & m) == 8'h00) ? clsu_pkg::FLAG_Z : 8'h00);
            end
            default: ;
          endcase
          // n and z from the result
          case (u_r.op)
            clsu_pkg::OP_LD, clsu_pkg::OP_AND, clsu_pkg::OP_ORA, clsu_pkg::OP_EOR,
            clsu_pkg::OP_TAX, clsu_pkg::OP_TAY, clsu_pkg::OP_TXA, clsu_pkg::OP_TYA,
            clsu_pkg::OP_TSX: begin
              p_nxt = (p_r & ~(clsu_pkg::FLAG_N | clsu_pkg::FLAG_Z))
                    | (res & clsu_pkg::FLAG_N)
                    | ((res == 8'h00) ? clsu_pkg::FLAG_Z : 8'h00);
            end
            default: ;
          endcase
          if (u_r.mode == clsu_pkg::M_HRD) rb_nxt = rdata_r;
        end
      end
      default: state_nxt = clsu_pkg::ST_IDLE;
    endcase
  end

  assign out_valid     = ovalid_r;
  assign out_status    = ostatus_r;
  assign out_acc       = oa_r;
  assign out_xreg      = ox_r;
  assign out_yreg      = oy_r;
  assign out_stack_ptr = osp_r;
  assign out_flags     = op_r;
  assign out_read_byte = orb_r;

endmodule

// ===== tb/tb_cpu_load_store_logic_unit.sv =====
module tb_cpu_load_store_logic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 400000;
  localparam int N_RANDOM  = 350;

  typedef struct {
    clsu_pkg::kind_t kind;
    logic [7:0] opc;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] hd;
    bit         hold;
  } cpu_item_t;

  typedef struct {
    logic       status;
    logic [7:0] acc;
    logic [7:0] xr;
    logic [7:0] yr;
    logic [7:0] sp;
    logic [7:0] fl;
    logic [7:0] rb;
  } reg_snap_t;

  // named opcodes used by the directed part
  localparam logic [7:0] OPC_BRK = 8'h00, OPC_SED = 8'hF8, OPC_SEI = 8'h78;
  localparam logic [7:0] OPC_LDA_IMM = 8'hA9, OPC_LDX_IMM = 8'hA2, OPC_LDY_IMM = 8'hA0;
  localparam logic [7:0] OPC_TAX = 8'hAA, OPC_TAY = 8'hA8, OPC_TXA = 8'h8A;
  localparam logic [7:0] OPC_TYA = 8'h98, OPC_TSX = 8'hBA, OPC_TXS = 8'h9A;
  localparam logic [7:0] OPC_STA_ZP = 8'h85, OPC_STA_ZPX = 8'h95, OPC_LDA_ABX = 8'hBD;
  localparam logic [7:0] OPC_LDA_INX = 8'hA1, OPC_LDA_INY = 8'hB1, OPC_STA_INY = 8'h91;
  localparam logic [7:0] OPC_BIT_ZP = 8'h24, OPC_BIT_ABS = 8'h2C, OPC_AND_IMM = 8'h29;
  localparam logic [7:0] OPC_ORA_IMM = 8'h09, OPC_EOR_IMM = 8'h49, OPC_ILLEGAL = 8'h02;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_kind;
  logic [7:0] in_opcode, in_operand_lo, in_operand_hi, in_host_data;
  logic out_status;
  logic [7:0] out_acc, out_xreg, out_yreg, out_stack_ptr, out_flags, out_read_byte;

  cpu_load_store_logic_unit i_dut (.*);

  // shadow cpu state
  logic [7:0] sh_a, sh_x, sh_y, sh_sp, sh_fl;
  logic [7:0] sh_mem [0:65535];
  bit         sh_written [0:65535];

  cpu_item_t pending_items[$];
  reg_snap_t expected_regs[$];
  int sent_cnt, got_cnt, errors, cycles, n_exec, n_host, n_bad;

  byte unsigned legal_opcodes[] = '{
    8'h00, 8'hF8, 8'h78, 8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4,
    8'hAC, 8'hBC, 8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'h84,
    8'h94, 8'h8C, 8'h86, 8'h96, 8'h8E, 8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81,
    8'h91, 8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hBA, 8'h9A, 8'h24, 8'h2C,
    8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31,
    8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11,
    8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51};

  // opcode decode table
  function automatic void decode_opc(input logic [7:0] opc, output clsu_pkg::op_t op,
                                     output clsu_pkg::mode_t md,
                                     output clsu_pkg::reg_sel_t rs);
    op = clsu_pkg::OP_BAD; md = clsu_pkg::M_NONE; rs = clsu_pkg::R_A;
    case (opc)
      8'h00, 8'hF8: op = clsu_pkg::OP_NOP;
      8'h78: op = clsu_pkg::OP_SEI;
      8'hA2: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_IMM; rs = clsu_pkg::R_X; end
      8'hA6: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZP;  rs = clsu_pkg::R_X; end
      8'hB6: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZPY; rs = clsu_pkg::R_X; end
      8'hAE: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABS; rs = clsu_pkg::R_X; end
      8'hBE: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABY; rs = clsu_pkg::R_X; end
      8'hA0: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_IMM; rs = clsu_pkg::R_Y; end
      8'hA4: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZP;  rs = clsu_pkg::R_Y; end
      8'hB4: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZPX; rs = clsu_pkg::R_Y; end
      8'hAC: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABS; rs = clsu_pkg::R_Y; end
      8'hBC: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABX; rs = clsu_pkg::R_Y; end
      8'hA9: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_IMM; end
      8'hA5: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZP;  end
      8'hB5: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ZPX; end
      8'hAD: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABS; end
      8'hBD: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABX; end
      8'hB9: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_ABY; end
      8'hA1: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_INX; end
      8'hB1: begin op = clsu_pkg::OP_LD; md = clsu_pkg::M_INY; end
      8'h84: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZP;  rs = clsu_pkg::R_Y; end
      8'h94: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZPX; rs = clsu_pkg::R_Y; end
      8'h8C: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ABS; rs = clsu_pkg::R_Y; end
      8'h86: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZP;  rs = clsu_pkg::R_X; end
      8'h96: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZPY; rs = clsu_pkg::R_X; end
      8'h8E: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ABS; rs = clsu_pkg::R_X; end
      8'h85: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZP;  end
      8'h95: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ZPX; end
      8'h8D: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ABS; end
      8'h9D: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ABX; end
      8'h99: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_ABY; end
      8'h81: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_INX; end
      8'h91: begin op = clsu_pkg::OP_ST; md = clsu_pkg::M_INY; end
      8'hAA: op = clsu_pkg::OP_TAX;
      8'hA8: op = clsu_pkg::OP_TAY;
      8'h8A: op = clsu_pkg::OP_TXA;
      8'h98: op = clsu_pkg::OP_TYA;
      8'hBA: op = clsu_pkg::OP_TSX;
      8'h9A: op = clsu_pkg::OP_TXS;
      8'h24: begin op = clsu_pkg::OP_BIT; md = clsu_pkg::M_ZP;  end
      8'h2C: begin op = clsu_pkg::OP_BIT; md = clsu_pkg::M_ABS; end
      default: begin
        // logic group column layout
        case (opc[7:5])
          3'b001:  op = clsu_pkg::OP_AND;
          3'b000:  op = clsu_pkg::OP_ORA;
          3'b010:  op = clsu_pkg::OP_EOR;
          default: op = clsu_pkg::OP_BAD;
        endcase
        case (opc[4:0])
          5'h09: md = clsu_pkg::M_IMM;
          5'h05: md = clsu_pkg::M_ZP;
          5'h15: md = clsu_pkg::M_ZPX;
          5'h0D: md = clsu_pkg::M_ABS;
          5'h1D: md = clsu_pkg::M_ABX;
          5'h19: md = clsu_pkg::M_ABY;
          5'h01: md = clsu_pkg::M_INX;
          5'h11: md = clsu_pkg::M_INY;
          default: op = clsu_pkg::OP_BAD;
        endcase
        if (op == clsu_pkg::OP_BAD) md = clsu_pkg::M_NONE;
      end
    endcase
  endfunction

  // effective address from current shadow state
  function automatic logic [15:0] operand_addr(clsu_pkg::mode_t md, logic [7:0] lo,
                                               logic [7:0] hi);
    logic [7:0] p;
    case (md)
      clsu_pkg::M_ZP:  return {8'h00, lo};
      clsu_pkg::M_ZPX: return {8'h00, lo + sh_x};
      clsu_pkg::M_ZPY: return {8'h00, lo + sh_y};
      clsu_pkg::M_ABS: return {hi, lo};
      clsu_pkg::M_ABX: return {hi, lo} + 16'(sh_x);
      clsu_pkg::M_ABY: return {hi, lo} + 16'(sh_y);
      clsu_pkg::M_INX: begin
        p = lo + sh_x;
        return {sh_mem[{8'h00, p + 8'h01}], sh_mem[{8'h00, p}]};
      end
      clsu_pkg::M_INY:
        return {sh_mem[{8'h00, lo + 8'h01}], sh_mem[{8'h00, lo}]} + 16'(sh_y);
      default: return 16'h0000;
    endcase
  endfunction

  function automatic void set_nz(logic [7:0] v);
    sh_fl = (sh_fl & ~(clsu_pkg::FLAG_N | clsu_pkg::FLAG_Z)) | (v & clsu_pkg::FLAG_N)
          | ((v == 8'h00) ? clsu_pkg::FLAG_Z : 8'h00);
  endfunction

  // apply one item to the shadow state and return the register snapshot
  function automatic reg_snap_t cpu_step(cpu_item_t it);
    reg_snap_t r;
    clsu_pkg::op_t op;
    clsu_pkg::mode_t md;
    clsu_pkg::reg_sel_t rs;
    logic [15:0] a;
    logic [7:0] m, src;
    r.status = 1'b0; r.rb = 8'h00;
    case (it.kind)
      clsu_pkg::KIND_HWR: begin
        sh_mem[{it.hi, it.lo}] = it.hd;
        sh_written[{it.hi, it.lo}] = 1'b1;
      end
      clsu_pkg::KIND_HRD: r.rb = sh_mem[{it.hi, it.lo}];
      clsu_pkg::KIND_BAD: r.status = 1'b1;
      default: begin
        decode_opc(it.opc, op, md, rs);
        if (op == clsu_pkg::OP_BAD) r.status = 1'b1;
        else begin
          a = operand_addr(md, it.lo, it.hi);
          m = (md == clsu_pkg::M_IMM) ? it.lo : sh_mem[a];
          src = (rs == clsu_pkg::R_X) ? sh_x : (rs == clsu_pkg::R_Y) ? sh_y : sh_a;
          case (op)
            clsu_pkg::OP_SEI: sh_fl = sh_fl | clsu_pkg::FLAG_I;
            clsu_pkg::OP_LD: begin
              if (rs == clsu_pkg::R_X) sh_x = m;
              else if (rs == clsu_pkg::R_Y) sh_y = m;
              else sh_a = m;
              set_nz(m);
            end
            clsu_pkg::OP_ST: begin sh_mem[a] = src; sh_written[a] = 1'b1; end
            clsu_pkg::OP_AND: begin sh_a = sh_a & m; set_nz(sh_a); end
            clsu_pkg::OP_ORA: begin sh_a = sh_a | m; set_nz(sh_a); end
            clsu_pkg::OP_EOR: begin sh_a = sh_a ^ m; set_nz(sh_a); end
            clsu_pkg::OP_BIT:
              sh_fl = (sh_fl & ~(clsu_pkg::FLAG_N | clsu_pkg::FLAG_V | clsu_pkg::FLAG_Z))
                    | (m & (clsu_pkg::FLAG_N | clsu_pkg::FLAG_V))
                    | (((sh_a & m) == 8'h00) ? clsu_pkg::FLAG_Z : 8'h00);
            clsu_pkg::OP_TAX: begin sh_x = sh_a; set_nz(sh_x); end
            clsu_pkg::OP_TAY: begin sh_y = sh_a; set_nz(sh_y); end
            clsu_pkg::OP_TXA: begin sh_a = sh_x; set_nz(sh_a); end
            clsu_pkg::OP_TYA: begin sh_a = sh_y; set_nz(sh_a); end
            clsu_pkg::OP_TSX: begin sh_x = sh_sp; set_nz(sh_x); end
            clsu_pkg::OP_TXS: sh_sp = sh_x;
            default: ;
          endcase
        end
      end
    endcase
    r.acc = sh_a; r.xr = sh_x; r.yr = sh_y; r.sp = sh_sp; r.fl = sh_fl;
    return r;
  endfunction

  function automatic void queue_item(cpu_item_t it);
    pending_items.push_back(it);
    expected_regs.push_back(cpu_step(it));
  endfunction

  function automatic void queue_write(logic [15:0] a, logic [7:0] d, bit hold);
    cpu_item_t w;
    w.kind = clsu_pkg::KIND_HWR; w.opc = 8'($urandom); w.lo = a[7:0]; w.hi = a[15:8];
    w.hd = d; w.hold = hold;
    queue_item(w);
    n_host++;
  endfunction

  // queue an item, first writing any memory byte it would read unwritten
  function automatic void issue(cpu_item_t it);
    clsu_pkg::op_t op;
    clsu_pkg::mode_t md;
    clsu_pkg::reg_sel_t rs;
    logic [15:0] a;
    if (it.kind == clsu_pkg::KIND_HRD && !sh_written[{it.hi, it.lo}])
      queue_write({it.hi, it.lo}, 8'($urandom), 1'b0);
    if (it.kind == clsu_pkg::KIND_EXEC) begin
      decode_opc(it.opc, op, md, rs);
      if (op != clsu_pkg::OP_BAD && op != clsu_pkg::OP_ST && md != clsu_pkg::M_NONE &&
          md != clsu_pkg::M_IMM) begin
        a = operand_addr(md, it.lo, it.hi);
        if (!sh_written[a]) queue_write(a, 8'($urandom), 1'b0);
      end
      n_exec++;
    end else if (it.kind == clsu_pkg::KIND_BAD) n_bad++;
    else n_host++;
    queue_item(it);
  endfunction

  function automatic cpu_item_t mk(clsu_pkg::kind_t k, logic [7:0] opc, logic [7:0] lo,
                                   logic [7:0] hi);
    cpu_item_t it;
    it.kind = k; it.opc = opc; it.lo = lo; it.hi = hi; it.hd = 8'($urandom);
    it.hold = 1'b0;
    return it;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: bursts and gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    bit fire, drive;
    cpu_item_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0; gap_left = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        void'(pending_items.pop_front());
        sent_cnt++;
      end
      drive = 1'b0;
      if (in_valid && !fire) drive = 1'b1;
      else if (pending_items.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else if (pending_items[0].hold && got_cnt != sent_cnt) drive = 1'b0;
        else begin
          drive = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 20);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_valid <= drive;
      if (drive && !(in_valid && !fire)) begin
        nx = pending_items[0];
        in_kind <= nx.kind; in_opcode <= nx.opc; in_operand_lo <= nx.lo;
        in_operand_hi <= nx.hi; in_host_data <= nx.hd;
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    reg_snap_t e;
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        got_cnt++;
        if (expected_regs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item", $time);
        end else begin
          e = expected_regs.pop_front();
          if (out_status !== e.status) begin errors++;
            $display("%0t: status exp %h got %h", $time, e.status, out_status); end
          if (out_acc !== e.acc) begin errors++;
            $display("%0t: acc exp %h got %h", $time, e.acc, out_acc); end
          if (out_xreg !== e.xr) begin errors++;
            $display("%0t: xreg exp %h got %h", $time, e.xr, out_xreg); end
          if (out_yreg !== e.yr) begin errors++;
            $display("%0t: yreg exp %h got %h", $time, e.yr, out_yreg); end
          if (out_stack_ptr !== e.sp) begin errors++;
            $display("%0t: stack_ptr exp %h got %h", $time, e.sp, out_stack_ptr); end
          if (out_flags !== e.fl) begin errors++;
            $display("%0t: flags exp %h got %h", $time, e.fl, out_flags); end
          if (out_read_byte !== e.rb) begin errors++;
            $display("%0t: read_byte exp %h got %h", $time, e.rb, out_read_byte); end
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb_cpu_load_store_logic_unit: FAIL");
      $finish;
    end
  end

  initial begin
    cpu_item_t it;
    int pick;
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
    in_kind = clsu_pkg::KIND_EXEC; in_opcode = 8'h00; in_operand_lo = 8'h00;
    in_operand_hi = 8'h00; in_host_data = 8'h00;
    sent_cnt = 0; got_cnt = 0; errors = 0; cycles = 0; stall_mode = 0;
    n_exec = 0; n_host = 0; n_bad = 0;
    sh_a = 8'h00; sh_x = 8'h00; sh_y = 8'h00;
    sh_sp = clsu_pkg::SP_RESET; sh_fl = clsu_pkg::FLAGS_RESET;
    for (int i = 0; i < 65536; i++) begin sh_mem[i] = 8'h00; sh_written[i] = 1'b0; end

    // fill page zero so every pointer is defined
    for (int i = 0; i < 256; i++) queue_write(16'(i), 8'($urandom), 1'b0);

    // directed: reset values, extremes, wraps and every operation
    it = mk(clsu_pkg::KIND_EXEC, OPC_BRK, 8'h00, 8'h00); it.hold = 1'b1; issue(it);
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDA_IMM, 8'h00, 8'hFF));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDA_IMM, 8'hFF, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDX_IMM, 8'hFF, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDY_IMM, 8'h80, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_STA_ZPX, 8'h05, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDA_ABX, 8'hFF, 8'hFF));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDA_INX, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDA_INY, 8'hFF, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_STA_INY, 8'hFE, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TSX, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TAY, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TXA, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TAX, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TYA, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_LDX_IMM, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_TXS, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_SEI, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_SED, 8'h00, 8'h00));
    queue_write(16'h00F0, 8'hC0, 1'b0);
    issue(mk(clsu_pkg::KIND_EXEC, OPC_BIT_ZP, 8'hF0, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_BIT_ABS, 8'h34, 8'h12));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_AND_IMM, 8'h0F, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_ORA_IMM, 8'hA5, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_EOR_IMM, 8'hFF, 8'h00));
    issue(mk(clsu_pkg::KIND_EXEC, OPC_ILLEGAL, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_BAD, OPC_BRK, 8'h00, 8'h00));
    issue(mk(clsu_pkg::KIND_HRD, OPC_BRK, 8'hFF, 8'hFF));

    // random mix, mostly legal opcodes on a few hot pages
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      it = mk(clsu_pkg::KIND_EXEC, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) != 0) it.hi = 8'($urandom_range(0, 3));
      if (pick < 70) it.opc = legal_opcodes[$urandom_range(0, legal_opcodes.size() - 1)];
      else if (pick < 80) ;
      else if (pick < 89) it.kind = clsu_pkg::KIND_HWR;
      else if (pick < 97) it.kind = clsu_pkg::KIND_HRD;
      else it.kind = clsu_pkg::KIND_BAD;
      if (i == N_RANDOM / 2) it.hold = 1'b1;
      issue(it);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && expected_regs.size() == 0);
    repeat (30) @(posedge clk);
    $display("covered %0d instructions, %0d host accesses, %0d bad kinds, %0d results",
             n_exec, n_host, n_bad, got_cnt);
    if (errors == 0 && expected_regs.size() == 0)
      $display("tb_cpu_load_store_logic_unit: PASS");
    else
      $display("tb_cpu_load_store_logic_unit: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/clsu_pkg.sv
hw/rtl/clsu_front.sv
hw/rtl/clsu_back.sv
hw/rtl/cpu_load_store_logic_unit.sv
tb/tb_cpu_load_store_logic_unit.sv
